/* hw/rtl/mde_pkg.sv */
// shared types and constants for the depth-first maze exploration table
`timescale 1ns / 1ps
package mde_pkg;

   localparam int NODE_W = 11;
   localparam int TYPE_W = 3;
   localparam int EXIT_W = 3;

   localparam logic [NODE_W-1:0] NONE_ID = '1;

   localparam logic KIND_RESTART = 1'b0;
   localparam logic KIND_VISIT   = 1'b1;

   localparam logic REG_DEAD_END = 1'b0;
   localparam logic REG_MAZE_END = 1'b1;

   localparam int EXIT_LEFT  = 0;
   localparam int EXIT_FRONT = 1;
   localparam int EXIT_RIGHT = 2;

   typedef enum logic [2:0] {
      ACT_ERROR = 3'd0,
      ACT_LEFT  = 3'd1,
      ACT_FRONT = 3'd2,
      ACT_RIGHT = 3'd3,
      ACT_BACK  = 3'd4,
      ACT_DONE  = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_APPLY
   } state_type;

   typedef struct packed {
      action_type          action;
      logic [EXIT_W-1:0]   explored;
      logic                exhausted;
   } decision_type;

endpackage

/* hw/rtl/mde_decide.sv */
// next-move decision for one node record
`timescale 1ns / 1ps
module mde_decide (
   input  logic [mde_pkg::TYPE_W-1:0] dead_code,
   input  logic [mde_pkg::TYPE_W-1:0] maze_code,
   input  logic [mde_pkg::TYPE_W-1:0] node_type,
   input  logic [mde_pkg::EXIT_W-1:0] exits,
   input  logic [mde_pkg::EXIT_W-1:0] explored,
   input  logic                       has_parent,
   output mde_pkg::decision_type      decision
);
   import mde_pkg::*;

   logic [EXIT_W-1:0] free_bits;
   logic              terminal;
   logic              retire;

   always_comb begin
      free_bits = exits & ~explored;
      terminal  = (node_type == dead_code) || (node_type == maze_code);
      retire    = 1'b0;
      decision.explored  = explored;
      decision.exhausted = 1'b0;
      decision.action    = ACT_ERROR;
      if (terminal) begin
         retire = 1'b1;
      end else if (free_bits[EXIT_LEFT]) begin
         decision.explored[EXIT_LEFT] = 1'b1;
         decision.action = ACT_LEFT;
      end else if (free_bits[EXIT_FRONT]) begin
         decision.explored[EXIT_FRONT] = 1'b1;
         decision.action = ACT_FRONT;
      end else if (free_bits[EXIT_RIGHT]) begin
         decision.explored[EXIT_RIGHT] = 1'b1;
         decision.action = ACT_RIGHT;
      end else begin
         retire = 1'b1;
      end
      if (retire) begin
         decision.exhausted = 1'b1;
         decision.action    = has_parent ? ACT_BACK : ACT_DONE;
      end
   end

endmodule

/* hw/rtl/maze_dfs_explorer.sv */
// top level: depth-first maze exploration table with apb register port
//
//   channel | direction | handshake                  | moves
//   req     | in        | req_valid / req_stall      | restart or visit transaction
//   rsp     | out       | rsp_valid / rsp_stall      | one result per visit
//   csr     | in/out    | psel, penable, pwrite, ... | dead_end_code, maze_end_code
//
// a restart is taken in idle with no scan; a visit scans the table from slot 0 up to the
// slot that holds the node, or across all count entries when it is new, the record memory
// read port scanning one entry a cycle
// synchronous reset; no clearing pass, the fill count bounds every search
// a held result does not block the next accept; a finished visit waits in apply until
// the result register is free
`timescale 1ns / 1ps
module maze_dfs_explorer #(
   parameter int MAX_NODES = 64,
   parameter int ID_BITS   = 10
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_kind,
   input  logic signed [mde_pkg::NODE_W-1:0]   req_node_id,
   input  logic signed [mde_pkg::NODE_W-1:0]   req_parent_id,
   input  logic        [mde_pkg::TYPE_W-1:0]   req_node_type,
   input  logic                                req_exit_left,
   input  logic                                req_exit_front,
   input  logic                                req_exit_right,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic        [2:0]                   rsp_action,
   output logic signed [mde_pkg::NODE_W-1:0]   rsp_node_out,
   output logic signed [mde_pkg::NODE_W-1:0]   rsp_from_out,
   output logic                                rsp_created_valid,
   output logic        [ID_BITS-1:0]           rsp_created_id,
   output logic        [mde_pkg::TYPE_W-1:0]   rsp_created_type,
   output logic signed [mde_pkg::NODE_W-1:0]   rsp_created_parent,
   output logic                                rsp_edge_valid,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic        [2:0]                   paddr,
   input  logic        [31:0]                  pwdata,
   output logic        [31:0]                  prdata,
   output logic                                pready
);
   import mde_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int EW = (ID_BITS + 1 > NODE_W) ? ID_BITS + 1 : NODE_W;

   typedef struct packed {
      logic [EW-1:0]     id;
      logic [TYPE_W-1:0] type_code;
      logic [NODE_W-1:0] parent;
      logic [EXIT_W-1:0] exits;
      logic [EXIT_W-1:0] explored;
      logic              exhausted;
   } rec_type;

   rec_type mem [MAX_NODES];

   state_type state_ff, state_in;

   logic [TYPE_W-1:0] dead_code_ff, dead_code_in;
   logic [TYPE_W-1:0] maze_code_ff, maze_code_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [ID_BITS-1:0] next_id_ff, next_id_in;

   logic signed [NODE_W-1:0] nid_ff, nid_in;
   logic signed [NODE_W-1:0] pid_ff, pid_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [EXIT_W-1:0] exits_ff, exits_in;

   logic [CW-1:0] scan_idx_ff, scan_idx_in;
   logic [CW-1:0] rd_slot_ff;
   logic          rd_vld_ff;
   rec_type       rdata_ff;

   rec_type       rec_ff, rec_in;
   logic [CW-1:0] slot_ff, slot_in;
   logic          created_ff, created_in;
   logic          err_ff, err_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   action_type               rsp_action_ff, rsp_action_in;
   logic signed [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic signed [NODE_W-1:0] rsp_from_ff, rsp_from_in;
   logic                     rsp_cvalid_ff, rsp_cvalid_in;
   logic [ID_BITS-1:0]       rsp_cid_ff, rsp_cid_in;
   logic [TYPE_W-1:0]        rsp_ctype_ff, rsp_ctype_in;
   logic signed [NODE_W-1:0] rsp_cparent_ff, rsp_cparent_in;
   logic                     rsp_edge_ff, rsp_edge_in;

   logic          req_take;
   logic          restart_take;
   logic          visit_take;
   logic          out_free;
   logic          cfg_wr;
   logic [EW-1:0] nid_ext;
   logic          hit;
   logic          miss;
   logic          rd_en;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   rec_type       wr_data;
   rec_type       start_rec;
   rec_type       upd_rec;
   logic          scan_busy;
   logic          apply_go;
   decision_type  decision;

   mde_decide u_decide (
      .dead_code  (dead_code_ff),
      .maze_code  (maze_code_ff),
      .node_type  (rec_ff.type_code),
      .exits      (rec_ff.exits),
      .explored   (rec_ff.explored),
      .has_parent (rec_ff.parent != NONE_ID),
      .decision   (decision)
   );

   assign pready       = 1'b1;
   assign cfg_wr       = psel & penable & pwrite;
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign req_take     = req_valid && !req_stall;
   assign restart_take = req_take && (req_kind == KIND_RESTART);
   assign visit_take   = req_take && (req_kind == KIND_VISIT);
   assign nid_ext      = EW'(nid_ff);
   assign scan_busy    = (state_ff == ST_SCAN);
   assign hit          = scan_busy && rd_vld_ff && (rdata_ff.id == nid_ext);
   assign miss         = scan_busy && !hit && (scan_idx_ff >= count_ff);
   assign apply_go     = (state_ff == ST_APPLY) && out_free;

   always_comb begin
      start_rec.id        = EW'(req_node_id);
      start_rec.type_code = req_node_type;
      start_rec.parent    = NONE_ID;
      start_rec.exits     = {1'b0, req_exit_front, 1'b0};
      start_rec.explored  = '0;
      start_rec.exhausted = 1'b0;
      upd_rec             = rec_ff;
      upd_rec.explored    = decision.explored;
      upd_rec.exhausted   = rec_ff.exhausted | decision.exhausted;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (visit_take) state_in = ST_SCAN;
         ST_SCAN:  if (hit || miss) state_in = ST_APPLY;
         ST_APPLY: if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = start_rec;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            wr_en     = req_valid && (req_kind == KIND_RESTART);
         end
         ST_SCAN: begin
            rd_en = !hit && (scan_idx_ff < count_ff);
         end
         ST_APPLY: begin
            wr_en   = out_free && !err_ff;
            wr_addr = slot_ff[AW-1:0];
            wr_data = upd_rec;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_comb begin
      dead_code_in   = dead_code_ff;
      maze_code_in   = maze_code_ff;
      count_in       = count_ff;
      next_id_in     = next_id_ff;
      nid_in         = nid_ff;
      pid_in         = pid_ff;
      type_in        = type_ff;
      exits_in       = exits_ff;
      scan_idx_in    = scan_idx_ff;
      rec_in         = rec_ff;
      slot_in        = slot_ff;
      created_in     = created_ff;
      err_in         = err_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_action_in  = rsp_action_ff;
      rsp_node_in    = rsp_node_ff;
      rsp_from_in    = rsp_from_ff;
      rsp_cvalid_in  = rsp_cvalid_ff;
      rsp_cid_in     = rsp_cid_ff;
      rsp_ctype_in   = rsp_ctype_ff;
      rsp_cparent_in = rsp_cparent_ff;
      rsp_edge_in    = rsp_edge_ff;

      if (cfg_wr) begin
         unique case (paddr[2])
            REG_DEAD_END: dead_code_in = pwdata[TYPE_W-1:0];
            REG_MAZE_END: maze_code_in = pwdata[TYPE_W-1:0];
            default:      dead_code_in = dead_code_ff;
         endcase
      end

      if (restart_take) begin
         count_in   = CW'(1);
         next_id_in = ID_BITS'(32'(req_node_id) + 32'sd1);
      end

      if (visit_take) begin
         nid_in      = req_node_id;
         pid_in      = req_parent_id;
         type_in     = req_node_type;
         exits_in    = {req_exit_right, req_exit_front, req_exit_left};
         scan_idx_in = '0;
      end

      if (rd_en) begin
         scan_idx_in = scan_idx_ff + CW'(1);
      end

      if (hit) begin
         rec_in     = rdata_ff;
         slot_in    = rd_slot_ff;
         created_in = 1'b0;
         err_in     = 1'b0;
      end else if (miss) begin
         rec_in.id        = EW'(next_id_ff);
         rec_in.type_code = type_ff;
         rec_in.parent    = pid_ff;
         rec_in.exits     = exits_ff;
         rec_in.explored  = '0;
         rec_in.exhausted = 1'b0;
         slot_in          = count_ff;
         created_in       = (count_ff < CW'(MAX_NODES));
         err_in           = (count_ff >= CW'(MAX_NODES));
      end

      if (apply_go) begin
         rsp_valid_in = 1'b1;
         if (err_ff) begin
            rsp_action_in  = ACT_ERROR;
            rsp_node_in    = nid_ff;
            rsp_from_in    = pid_ff;
            rsp_cvalid_in  = 1'b0;
            rsp_cid_in     = '0;
            rsp_ctype_in   = '0;
            rsp_cparent_in = '0;
            rsp_edge_in    = 1'b0;
         end else begin
            rsp_action_in = decision.action;
            if (decision.action == ACT_BACK) begin
               rsp_node_in = rec_ff.parent;
               rsp_from_in = rec_ff.id[NODE_W-1:0];
            end else begin
               rsp_node_in = rec_ff.id[NODE_W-1:0];
               rsp_from_in = pid_ff;
            end
            rsp_cvalid_in  = created_ff;
            rsp_cid_in     = created_ff ? rec_ff.id[ID_BITS-1:0] : '0;
            rsp_ctype_in   = created_ff ? rec_ff.type_code : '0;
            rsp_cparent_in = created_ff ? pid_ff : '0;
            rsp_edge_in    = created_ff && (pid_ff != NONE_ID);
            if (created_ff) begin
               count_in   = count_ff + CW'(1);
               next_id_in = next_id_ff + ID_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dead_code_ff <= TYPE_W'(1);
         maze_code_ff <= TYPE_W'(2);
         count_ff     <= '0;
         next_id_ff   <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dead_code_ff <= dead_code_in;
         maze_code_ff <= maze_code_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         rd_vld_ff    <= rd_en;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nid_ff         <= nid_in;
      pid_ff         <= pid_in;
      type_ff        <= type_in;
      exits_ff       <= exits_in;
      scan_idx_ff    <= scan_idx_in;
      rd_slot_ff     <= scan_idx_ff;
      rec_ff         <= rec_in;
      slot_ff        <= slot_in;
      created_ff     <= created_in;
      err_ff         <= err_in;
      rsp_action_ff  <= rsp_action_in;
      rsp_node_ff    <= rsp_node_in;
      rsp_from_ff    <= rsp_from_in;
      rsp_cvalid_ff  <= rsp_cvalid_in;
      rsp_cid_ff     <= rsp_cid_in;
      rsp_ctype_ff   <= rsp_ctype_in;
      rsp_cparent_ff <= rsp_cparent_in;
      rsp_edge_ff    <= rsp_edge_in;
   end

   // record memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[scan_idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_DEAD_END: prdata = 32'(dead_code_ff);
         REG_MAZE_END: prdata = 32'(maze_code_ff);
         default:      prdata = '0;
      endcase
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_action         = rsp_action_ff;
   assign rsp_node_out       = rsp_node_ff;
   assign rsp_from_out       = rsp_from_ff;
   assign rsp_created_valid  = rsp_cvalid_ff;
   assign rsp_created_id     = rsp_cid_ff;
   assign rsp_created_type   = rsp_ctype_ff;
   assign rsp_created_parent = rsp_cparent_ff;
   assign rsp_edge_valid     = rsp_edge_ff;

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("record memory read and write in the same cycle");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= count_ff))
      else $error("scan index ran past the fill count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_NODES))
      else $error("fill count exceeds table depth");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY))
      else $error("result raised outside apply");

   a_apply_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPLY && !err_ff) |->
         (slot_ff < count_ff || (created_ff && slot_ff == count_ff)))
      else $error("write-back slot outside the filled table");

endmodule

/* bench/tb_maze_dfs_explorer.sv */
// self-checking testbench for the depth-first maze exploration table
`timescale 1ns / 1ps
module tb_maze_dfs_explorer;
   import mde_pkg::*;

   localparam int MAX_NODES     = 64;
   localparam int ID_BITS       = 10;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = MAX_NODES + 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int QUIET_LIMIT   = 3000;

   typedef struct {
      logic                     kind;
      logic signed [NODE_W-1:0] node_id;
      logic signed [NODE_W-1:0] parent_id;
      logic        [TYPE_W-1:0] node_type;
      logic        [EXIT_W-1:0] exits;
   } visit_req_type;

   typedef struct {
      action_type               action;
      logic signed [NODE_W-1:0] node_out;
      logic signed [NODE_W-1:0] from_out;
      logic                     created_valid;
      logic       [ID_BITS-1:0] created_id;
      logic        [TYPE_W-1:0] created_type;
      logic signed [NODE_W-1:0] created_parent;
      logic                     edge_valid;
   } move_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic                     req_kind       = KIND_RESTART;
   logic signed [NODE_W-1:0] req_node_id    = '0;
   logic signed [NODE_W-1:0] req_parent_id  = '0;
   logic        [TYPE_W-1:0] req_node_type  = '0;
   logic                     req_exit_left  = 1'b0;
   logic                     req_exit_front = 1'b0;
   logic                     req_exit_right = 1'b0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic        [2:0]        rsp_action;
   logic signed [NODE_W-1:0] rsp_node_out;
   logic signed [NODE_W-1:0] rsp_from_out;
   logic                     rsp_created_valid;
   logic       [ID_BITS-1:0] rsp_created_id;
   logic        [TYPE_W-1:0] rsp_created_type;
   logic signed [NODE_W-1:0] rsp_created_parent;
   logic                     rsp_edge_valid;

   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [2:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;
   logic [31:0] prdata;
   logic        pready;

   // predictor copy of the node table and registers
   logic signed [NODE_W-1:0] tab_id       [MAX_NODES];
   logic signed [NODE_W-1:0] tab_parent   [MAX_NODES];
   logic        [TYPE_W-1:0] tab_type     [MAX_NODES];
   logic        [EXIT_W-1:0] tab_exits    [MAX_NODES];
   logic        [EXIT_W-1:0] tab_explored [MAX_NODES];
   int                       node_count = 0;
   logic       [ID_BITS-1:0] next_id    = '0;
   logic        [TYPE_W-1:0] dead_code  = 3'd1;
   logic        [TYPE_W-1:0] exit_code  = 3'd2;

   move_type planned_moves [$];

   // walk steering
   move_type                 last_move;
   logic                     walk_at_start = 1'b0;
   logic signed [NODE_W-1:0] start_node    = '0;

   int fail_count   = 0;
   int send_gap_pct = 21;
   int rsp_hold_pct = 64;
   int hold_seq     = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;

   maze_dfs_explorer #(
      .MAX_NODES(MAX_NODES),
      .ID_BITS  (ID_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_node_id       (req_node_id),
      .req_parent_id     (req_parent_id),
      .req_node_type     (req_node_type),
      .req_exit_left     (req_exit_left),
      .req_exit_front    (req_exit_front),
      .req_exit_right    (req_exit_right),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_action        (rsp_action),
      .rsp_node_out      (rsp_node_out),
      .rsp_from_out      (rsp_from_out),
      .rsp_created_valid (rsp_created_valid),
      .rsp_created_id    (rsp_created_id),
      .rsp_created_type  (rsp_created_type),
      .rsp_created_parent(rsp_created_parent),
      .rsp_edge_valid    (rsp_edge_valid),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #4 clock = ~clock;

   function automatic visit_req_type make_req(input logic kind,
                                              input logic signed [NODE_W-1:0] node,
                                              input logic signed [NODE_W-1:0] parent,
                                              input logic [TYPE_W-1:0] ntype,
                                              input logic [EXIT_W-1:0] exits);
      visit_req_type r;
      r.kind      = kind;
      r.node_id   = node;
      r.parent_id = parent;
      r.node_type = ntype;
      r.exits     = exits;
      return r;
   endfunction

   task automatic plan_move(input visit_req_type r);
      move_type          m;
      int                slot;
      int                i;
      bit                found;
      logic [EXIT_W-1:0] free_bits;
      if (r.kind == KIND_RESTART) begin
         tab_id[0]       = r.node_id;
         tab_parent[0]   = NONE_ID;
         tab_type[0]     = r.node_type;
         tab_exits[0]    = r.exits & (3'b001 << EXIT_FRONT);
         tab_explored[0] = '0;
         node_count      = 1;
         next_id         = r.node_id[ID_BITS-1:0] + 1'b1;
         walk_at_start   = 1'b1;
         start_node      = r.node_id;
         return;
      end
      m.action         = ACT_ERROR;
      m.node_out       = r.node_id;
      m.from_out       = r.parent_id;
      m.created_valid  = 1'b0;
      m.created_id     = '0;
      m.created_type   = '0;
      m.created_parent = '0;
      m.edge_valid     = 1'b0;
      found = 1'b0;
      slot  = 0;
      for (i = 0; i < node_count; i++) begin
         if (!found && tab_id[i] == r.node_id) begin
            found = 1'b1;
            slot  = i;
         end
      end
      if (!found && node_count >= MAX_NODES) begin
         planned_moves.push_back(m);
         last_move     = m;
         walk_at_start = 1'b0;
         return;
      end
      if (!found) begin
         slot               = node_count;
         tab_id[slot]       = {1'b0, next_id};
         tab_parent[slot]   = r.parent_id;
         tab_type[slot]     = r.node_type;
         tab_exits[slot]    = r.exits;
         tab_explored[slot] = '0;
         node_count++;
         m.node_out       = {1'b0, next_id};
         m.created_valid  = 1'b1;
         m.created_id     = next_id;
         m.created_type   = r.node_type;
         m.created_parent = r.parent_id;
         m.edge_valid     = (r.parent_id != NONE_ID);
         next_id          = next_id + 1'b1;
      end
      free_bits = '0;
      if (tab_type[slot] != dead_code && tab_type[slot] != exit_code) begin
         free_bits = tab_exits[slot] & ~tab_explored[slot];
      end
      if (free_bits[EXIT_LEFT]) begin
         m.action = ACT_LEFT;
         tab_explored[slot][EXIT_LEFT] = 1'b1;
      end else if (free_bits[EXIT_FRONT]) begin
         m.action = ACT_FRONT;
         tab_explored[slot][EXIT_FRONT] = 1'b1;
      end else if (free_bits[EXIT_RIGHT]) begin
         m.action = ACT_RIGHT;
         tab_explored[slot][EXIT_RIGHT] = 1'b1;
      end else if (tab_parent[slot] != NONE_ID) begin
         m.action   = ACT_BACK;
         m.from_out = tab_id[slot];
         m.node_out = tab_parent[slot];
      end else begin
         m.action = ACT_DONE;
      end
      planned_moves.push_back(m);
      last_move     = m;
      walk_at_start = 1'b0;
   endtask

   task automatic send_item(input visit_req_type r);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= r.kind;
      req_node_id    <= r.node_id;
      req_parent_id  <= r.parent_id;
      req_node_type  <= r.node_type;
      req_exit_left  <= r.exits[EXIT_LEFT];
      req_exit_front <= r.exits[EXIT_FRONT];
      req_exit_right <= r.exits[EXIT_RIGHT];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      plan_move(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (planned_moves.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [TYPE_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {29'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[TYPE_W-1:0] !== val) begin
         $error("csr readback expected %0d got %0d", val, prdata[TYPE_W-1:0]);
         fail_count++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == REG_DEAD_END) dead_code = val;
      else exit_code = val;
   endtask

   function automatic logic [TYPE_W-1:0] pick_type();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25) return dead_code;
      if (roll < 33) return exit_code;
      return TYPE_W'($urandom_range(7));
   endfunction

   // mostly a robot following the planned moves, with noise and stray revisits
   function automatic visit_req_type next_walk_item();
      visit_req_type r;
      int            roll;
      roll = $urandom_range(99);
      r = make_req(KIND_VISIT, NODE_W'($urandom), NODE_W'($urandom), pick_type(),
                   EXIT_W'($urandom));
      if (roll < 6) begin
         r.kind = 1'($urandom);
         return r;
      end
      if (roll < 8) begin
         r.kind = KIND_RESTART;
         return r;
      end
      if (roll < 13 && node_count > 0) begin
         r.node_id = tab_id[$urandom_range(node_count - 1)];
         return r;
      end
      if (walk_at_start) begin
         r.node_id   = start_node;
         r.parent_id = NONE_ID;
         return r;
      end
      case (last_move.action) inside
         ACT_LEFT, ACT_FRONT, ACT_RIGHT: begin
            r.parent_id = last_move.node_out;
         end
         ACT_BACK: begin
            r.node_id   = last_move.node_out;
            r.parent_id = last_move.from_out;
         end
         default: begin
            r.kind = KIND_RESTART;
         end
      endcase
      return r;
   endfunction

   task automatic test_directed_actions();
      send_item(make_req(KIND_RESTART, 5, 0, 3'd0, 3'b111));
      send_item(make_req(KIND_VISIT, 5, NONE_ID, 3'd0, 3'b000));
      send_item(make_req(KIND_VISIT, 100, 5, 3'd0, 3'b111));
      send_item(make_req(KIND_VISIT, 6, 5, 3'd4, 3'b000));
      send_item(make_req(KIND_VISIT, 6, 5, 3'd4, 3'b000));
      send_item(make_req(KIND_VISIT, 6, 5, 3'd4, 3'b000));
      send_item(make_req(KIND_VISIT, 5, 6, 3'd0, 3'b000));
      send_item(make_req(KIND_VISIT, 200, 6, dead_code, 3'b111));
      send_item(make_req(KIND_VISIT, 300, 6, exit_code, 3'b111));
      send_item(make_req(KIND_VISIT, 400, NONE_ID, 3'd0, 3'b000));
      send_item(make_req(KIND_VISIT, NONE_ID, 1023, 3'd7, 3'b101));
      // start id at the top of the range, next id wraps to zero
      send_item(make_req(KIND_RESTART, 1023, NONE_ID, 3'd7, 3'b010));
      send_item(make_req(KIND_VISIT, 1023, NONE_ID, 3'd0, 3'b000));
      send_item(make_req(KIND_VISIT, -1024, 1023, 3'd0, 3'b110));
      send_item(make_req(KIND_VISIT, 0, 1023, 3'd0, 3'b000));
      send_item(make_req(KIND_VISIT, 0, 1023, 3'd0, 3'b000));
      send_item(make_req(KIND_RESTART, NONE_ID, 1023, dead_code, 3'b010));
      send_item(make_req(KIND_VISIT, NONE_ID, NONE_ID, 3'd0, 3'b000));
      send_item(make_req(KIND_VISIT, NONE_ID, 7, 3'd3, 3'b111));
   endtask

   task automatic test_walk_phase(input logic [TYPE_W-1:0] dead_val,
                                  input logic [TYPE_W-1:0] exit_val, input int n_items);
      wait_drained();
      write_csr(REG_DEAD_END, dead_val);
      write_csr(REG_MAZE_END, exit_val);
      repeat (n_items) send_item(next_walk_item());
   endtask

   task automatic test_backpressure();
      hold_seq++;
      repeat (30) send_item(next_walk_item());
      wait_drained();
   endtask

   task automatic test_table_full();
      int k;
      send_item(make_req(KIND_RESTART, 0, NONE_ID, 3'd4, 3'b010));
      // no handed-out id is negative, so these fill the table and overflow it
      for (k = 0; k < MAX_NODES + 2; k++) begin
         send_item(make_req(KIND_VISIT, NODE_W'(-2 - k), NODE_W'($urandom_range(63)),
                            pick_type(), EXIT_W'($urandom)));
      end
      send_item(make_req(KIND_VISIT, 0, NONE_ID, 3'd0, 3'b000));
      send_item(make_req(KIND_VISIT, 5, 0, 3'd0, 3'b000));
      send_item(make_req(KIND_RESTART, NODE_W'($urandom), NODE_W'($urandom), pick_type(),
                         EXIT_W'($urandom)));
   endtask

   task automatic check_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $error("%s expected %0d got %0d", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : rsp_side
      move_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (planned_moves.size() == 0) begin
               $error("unexpected result transaction, action %0d", rsp_action);
               fail_count++;
            end else begin
               want = planned_moves.pop_front();
               check_field("action", want.action, rsp_action);
               check_field("node_out", want.node_out, rsp_node_out);
               check_field("from_out", want.from_out, rsp_from_out);
               check_field("created_valid", want.created_valid, rsp_created_valid);
               check_field("created_id", want.created_id, rsp_created_id);
               check_field("created_type", want.created_type, rsp_created_type);
               check_field("created_parent", want.created_parent, rsp_created_parent);
               check_field("edge_valid", want.edge_valid, rsp_edge_valid);
            end
         end
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_actions();
      test_walk_phase(3'd0, 3'd7, 290);
      test_walk_phase(3'd1, 3'd2, 290);
      test_backpressure();
      send_gap_pct = 64;
      rsp_hold_pct = 21;
      test_walk_phase(3'd7, 3'd0, 290);
      test_table_full();
      test_walk_phase(3'd3, 3'd3, 290);
      send_gap_pct = 0;
      rsp_hold_pct = 0;
      test_walk_phase(3'd0, 3'd0, 290);
      test_walk_phase(3'd7, 3'd7, 290);
      wait_drained();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/mde_pkg.sv
hw/rtl/mde_decide.sv
hw/rtl/maze_dfs_explorer.sv
bench/tb_maze_dfs_explorer.sv
